### hdl/gtl_pkg.sv
`timescale 1ns / 1ps
// Package for the glyph table lookup block.
// Field widths, register indexes, metric record and controller/datapath bundles.
package gtl_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 1024;

    localparam int ACTION_W       = 1;
    localparam int ENTRY_INDEX_W  = 10;
    localparam int CODE_POINT_W   = 21;
    localparam int DIM_W          = 16;
    localparam int OFFSET_W       = 8;
    localparam int GLYPH_INDEX_W  = 10;
    localparam int ENTRY_COUNT_W  = 11;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_CONTINUOUS_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT     = 1'd1;

    localparam logic [ACTION_W-1:0] ACTION_LOAD   = 1'b0;
    localparam logic [ACTION_W-1:0] ACTION_LOOKUP = 1'b1;

    typedef struct packed {
        logic        [DIM_W-1:0]    width;
        logic        [DIM_W-1:0]    height;
        logic signed [OFFSET_W-1:0] offset_x;
        logic signed [OFFSET_W-1:0] offset_y;
        logic signed [OFFSET_W-1:0] advance;
    } gtl_metric_t;

    typedef struct packed {
        logic capture;
        logic write_entry;
        logic read_first;
        logic search_read;
        logic search_update;
        logic take_mid;
        logic take_diff;
        logic metric_read;
        logic out_load;
        logic out_hit;
    } gtl_cmd_t;

    typedef struct packed {
        logic in_lookup;
        logic count_zero;
        logic continuous;
        logic cont_hit;
        logic cmp_less;
        logic cmp_greater;
        logic exhausted;
        logic out_free;
    } gtl_status_t;

endpackage

### hdl/gtl_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the glyph table lookup block.
// Depends on gtl_pkg for the command and status bundles.
module gtl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  gtl_pkg::gtl_status_t  status,
    output gtl_pkg::gtl_cmd_t     cmd,
    output logic                  busy
);
    import gtl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_C_READ,
        ST_C_CHECK,
        ST_S_READ,
        ST_S_CHECK,
        ST_M_READ,
        ST_DONE_HIT,
        ST_DONE_MISS
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture     = 1'b1;
                    cmd.write_entry = !status.in_lookup;
                    if (!status.in_lookup || status.count_zero)
                        state_next = ST_DONE_MISS;
                    else if (status.continuous)
                        state_next = ST_C_READ;
                    else
                        state_next = ST_S_READ;
                end
            end
            ST_C_READ:
            begin
                cmd.read_first = 1'b1;
                state_next     = ST_C_CHECK;
            end
            ST_C_CHECK:
            begin
                if (status.cont_hit)
                begin
                    cmd.take_diff = 1'b1;
                    state_next    = ST_M_READ;
                end
                else
                    state_next = ST_DONE_MISS;
            end
            ST_S_READ:
            begin
                cmd.search_read = 1'b1;
                state_next      = ST_S_CHECK;
            end
            ST_S_CHECK:
            begin
                if (!status.cmp_less && !status.cmp_greater)
                begin
                    cmd.take_mid = 1'b1;
                    state_next   = ST_M_READ;
                end
                else
                begin
                    cmd.search_update = 1'b1;
                    state_next = status.exhausted ? ST_DONE_MISS : ST_S_READ;
                end
            end
            ST_M_READ:
            begin
                cmd.metric_read = 1'b1;
                state_next      = ST_DONE_HIT;
            end
            ST_DONE_HIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_hit  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DONE_MISS:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### hdl/gtl_datapath.sv
`timescale 1ns / 1ps
// Datapath for the glyph table lookup block: config registers, code and metric
// memories, search bounds and the output register. Depends on gtl_pkg.
module gtl_datapath #(
    parameter int TABLE_DEPTH = gtl_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [gtl_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [gtl_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic [gtl_pkg::ACTION_W-1:0]          action,
    input  logic [gtl_pkg::ENTRY_INDEX_W-1:0]     entry_index,
    input  logic [gtl_pkg::CODE_POINT_W-1:0]      code_point,
    input  logic [gtl_pkg::DIM_W-1:0]             glyph_width,
    input  logic [gtl_pkg::DIM_W-1:0]             glyph_height,
    input  logic signed [gtl_pkg::OFFSET_W-1:0]   offset_x,
    input  logic signed [gtl_pkg::OFFSET_W-1:0]   offset_y,
    input  logic signed [gtl_pkg::OFFSET_W-1:0]   advance,
    input  gtl_pkg::gtl_cmd_t                     cmd,
    output gtl_pkg::gtl_status_t                  status,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic                                  found,
    output logic [gtl_pkg::GLYPH_INDEX_W-1:0]     glyph_index,
    output logic [gtl_pkg::DIM_W-1:0]             out_width,
    output logic [gtl_pkg::DIM_W-1:0]             out_height,
    output logic signed [gtl_pkg::OFFSET_W-1:0]   out_offset_x,
    output logic signed [gtl_pkg::OFFSET_W-1:0]   out_offset_y,
    output logic signed [gtl_pkg::OFFSET_W-1:0]   out_advance
);
    import gtl_pkg::*;

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int DEPTHW = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W  = (DEPTHW > ENTRY_COUNT_W) ? DEPTHW : ENTRY_COUNT_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    logic                       continuous_reg;
    logic [ENTRY_COUNT_W-1:0]   entry_count_reg;
    logic [CNT_W-1:0]           active_n;

    logic [CODE_POINT_W-1:0]    code_mem [TABLE_DEPTH];
    gtl_metric_t                metric_mem [TABLE_DEPTH];
    logic [CODE_POINT_W-1:0]    code_rd_reg;
    gtl_metric_t                metric_rd_reg;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              code_addr;
    logic                       slot_ok;
    gtl_metric_t                wr_metric;

    logic [CODE_POINT_W-1:0]    key_reg;
    logic signed [CNT_W:0]      lo_reg;
    logic signed [CNT_W:0]      hi_reg;
    logic [CNT_W-1:0]           mid_reg;
    logic [CNT_W-1:0]           idx_reg;
    logic [CNT_W:0]             bound_sum;
    logic [CNT_W-1:0]           mid;
    logic signed [CNT_W:0]      next_lo;
    logic signed [CNT_W:0]      next_hi;
    logic [CODE_POINT_W-1:0]    cont_diff;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       found_reg;
    logic [GLYPH_INDEX_W-1:0]   glyph_index_reg;
    gtl_metric_t                out_metric_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            continuous_reg  <= 1'b0;
            entry_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_CONTINUOUS_MODE)
                continuous_reg <= cfg_data[0];
            else if (cfg_index == CFG_ENTRY_COUNT)
                entry_count_reg <= cfg_data[ENTRY_COUNT_W-1:0];
        end
    end

    assign active_n = (CNT_W'(entry_count_reg) > DEPTH_C) ? DEPTH_C : CNT_W'(entry_count_reg);

    // Table memories
    assign slot_ok   = CNT_W'(entry_index) < DEPTH_C;
    assign wr_addr   = AW'(CNT_W'(entry_index));
    assign bound_sum = {1'b0, lo_reg[CNT_W-1:0]} + {1'b0, hi_reg[CNT_W-1:0]};
    assign mid       = bound_sum[CNT_W:1];
    assign code_addr = cmd.read_first ? '0 : AW'(mid);

    always_comb
    begin
        wr_metric.width    = glyph_width;
        wr_metric.height   = glyph_height;
        wr_metric.offset_x = offset_x;
        wr_metric.offset_y = offset_y;
        wr_metric.advance  = advance;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && slot_ok)
        begin
            code_mem[wr_addr]   <= code_point;
            metric_mem[wr_addr] <= wr_metric;
        end
        if (cmd.read_first || cmd.search_read)
            code_rd_reg <= code_mem[code_addr];
        if (cmd.metric_read)
            metric_rd_reg <= metric_mem[AW'(idx_reg)];
    end

    // Search state
    assign next_lo   = $signed({1'b0, mid_reg}) + 2'sd1;
    assign next_hi   = $signed({1'b0, mid_reg}) - 2'sd1;
    assign cont_diff = key_reg - code_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg <= code_point;
            lo_reg  <= '0;
            hi_reg  <= $signed({1'b0, active_n}) - 2'sd1;
        end
        if (cmd.search_read)
            mid_reg <= mid;
        if (cmd.search_update)
        begin
            if (status.cmp_less)
                lo_reg <= next_lo;
            else
                hi_reg <= next_hi;
        end
        if (cmd.take_mid)
            idx_reg <= mid_reg;
        else if (cmd.take_diff)
            idx_reg <= cont_diff[CNT_W-1:0];
    end

    always_comb
    begin
        status.in_lookup   = (action == ACTION_LOOKUP);
        status.count_zero  = (active_n == '0);
        status.continuous  = continuous_reg;
        status.cont_hit    = (key_reg >= code_rd_reg)
                             && (cont_diff < CODE_POINT_W'(active_n));
        status.cmp_less    = (code_rd_reg < key_reg);
        status.cmp_greater = (code_rd_reg > key_reg);
        status.exhausted   = status.cmp_less ? (next_lo > hi_reg) : (lo_reg > next_hi);
        status.out_free    = !out_valid_reg || !out_stall;
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            found_reg       <= cmd.out_hit;
            glyph_index_reg <= cmd.out_hit ? idx_reg[GLYPH_INDEX_W-1:0] : '0;
            out_metric_reg  <= cmd.out_hit ? metric_rd_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign glyph_index  = glyph_index_reg;
    assign out_width    = out_metric_reg.width;
    assign out_height   = out_metric_reg.height;
    assign out_offset_x = out_metric_reg.offset_x;
    assign out_offset_y = out_metric_reg.offset_y;
    assign out_advance  = out_metric_reg.advance;

endmodule

### hdl/glyph_table_lookup.sv
`timescale 1ns / 1ps
// Glyph table lookup: loads of code point plus metrics, lookups by code point.
// Load: the entry is written on acceptance; a miss result loads once the output is free.
// Continuous lookup: one probe at entry 0. Binary-search lookup: ST_S_READ and ST_S_CHECK per
// probe through one code memory read port, up to ceil(log2(count+1)) probes.
// One transaction in flight; input reopens once its result loads.
// Reset clears the mode and count registers; table contents are undefined.
module glyph_table_lookup #(
    parameter int TABLE_DEPTH = gtl_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [gtl_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [gtl_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [gtl_pkg::ACTION_W-1:0]          action,
    input  logic [gtl_pkg::ENTRY_INDEX_W-1:0]     entry_index,
    input  logic [gtl_pkg::CODE_POINT_W-1:0]      code_point,
    input  logic [gtl_pkg::DIM_W-1:0]             glyph_width,
    input  logic [gtl_pkg::DIM_W-1:0]             glyph_height,
    input  logic signed [gtl_pkg::OFFSET_W-1:0]   offset_x,
    input  logic signed [gtl_pkg::OFFSET_W-1:0]   offset_y,
    input  logic signed [gtl_pkg::OFFSET_W-1:0]   advance,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  found,
    output logic [gtl_pkg::GLYPH_INDEX_W-1:0]     glyph_index,
    output logic [gtl_pkg::DIM_W-1:0]             out_width,
    output logic [gtl_pkg::DIM_W-1:0]             out_height,
    output logic signed [gtl_pkg::OFFSET_W-1:0]   out_offset_x,
    output logic signed [gtl_pkg::OFFSET_W-1:0]   out_offset_y,
    output logic signed [gtl_pkg::OFFSET_W-1:0]   out_advance
);
    import gtl_pkg::*;

    gtl_cmd_t    cmd;
    gtl_status_t status;
    logic        busy;

    gtl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    gtl_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .entry_index  (entry_index),
        .code_point   (code_point),
        .glyph_width  (glyph_width),
        .glyph_height (glyph_height),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .advance      (advance),
        .cmd          (cmd),
        .status       (status),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .found        (found),
        .glyph_index  (glyph_index),
        .out_width    (out_width),
        .out_height   (out_height),
        .out_offset_x (out_offset_x),
        .out_offset_y (out_offset_y),
        .out_advance  (out_advance)
    );

    assign in_stall = busy;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block idle right after accepting a transaction");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && out_stall))
        else $error("result loaded over a stalled result");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> glyph_index == '0 && out_width == '0 && out_height == '0)
        else $error("miss result carries nonzero fields");

    a_idle_no_reads: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !cmd.search_read && !cmd.metric_read && !cmd.out_load)
        else $error("datapath command issued while idle");

endmodule

### bench/glyph_table_lookup_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for glyph_table_lookup: a directed table, then random load and
// lookup traffic checked field by field against an in-bench copy of the glyph table.
// Depends on hdl/gtl_pkg.sv and hdl/glyph_table_lookup.sv.
module glyph_table_lookup_tb;

    import gtl_pkg::*;

    localparam int TABLE_DEPTH    = 1024;
    localparam int CODE_MAX       = 1114111;
    localparam int RANDOM_ITEMS   = 900;
    localparam int SETTLE_CYCLES  = 30;
    localparam int HOLD_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_ROWS  = 33;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [ENTRY_INDEX_W-1:0] slot;
        logic [CODE_POINT_W-1:0]  code;
        gtl_metric_t              metric;
    } glyph_item_t;

    typedef struct packed {
        logic                     found;
        logic [GLYPH_INDEX_W-1:0] glyph_idx;
        gtl_metric_t              metric;
    } glyph_result_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_LOOKUP} row_kind_e;

    typedef struct packed {
        row_kind_e                kind;
        logic [CFG_INDEX_W-1:0]   reg_index;
        logic [CFG_DATA_W-1:0]    reg_value;
        logic [ENTRY_INDEX_W-1:0] slot;
        logic [CODE_POINT_W-1:0]  code;
        gtl_metric_t              metric;
        logic                     miss;
    } directed_row_t;

    localparam gtl_metric_t M_ZERO = '0;
    localparam gtl_metric_t M_LOW  = '{16'h0000, 16'h0000, 8'h80, 8'h80, 8'h80};
    localparam gtl_metric_t M_HIGH = '{16'hFFFF, 16'hFFFF, 8'h7F, 8'h7F, 8'h7F};
    localparam gtl_metric_t M_ALT5 = '{16'h5555, 16'hAAAA, 8'h55, 8'hAA, 8'h55};
    localparam gtl_metric_t M_ALTA = '{16'hAAAA, 16'h5555, 8'hAA, 8'h55, 8'hAA};
    localparam gtl_metric_t M_MIX  = '{16'd12, 16'd17, 8'hFE, 8'h0B, 8'h0D};

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_LOOKUP, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'h000000, M_ZERO, 1'b1},
        '{ROW_LOAD, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'h000000, M_LOW, 1'b1},
        '{ROW_LOAD, CFG_ENTRY_COUNT, 11'd0, 10'd1023, 21'h10FFFF, M_HIGH, 1'b1},
        '{ROW_LOAD, CFG_ENTRY_COUNT, 11'd0, 10'd1, 21'h055555, M_ALT5, 1'b1},
        '{ROW_LOAD, CFG_ENTRY_COUNT, 11'd0, 10'd2, 21'h0AAAAA, M_ALTA, 1'b1},
        '{ROW_CFG, CFG_CONTINUOUS_MODE, 11'd1, 10'd0, 21'h000000, M_ZERO, 1'b0},
        '{ROW_LOOKUP, CFG_ENTRY_COUNT, 11'd0, 10'd5, 21'h000000, M_ZERO, 1'b1},
        '{ROW_CFG, CFG_CONTINUOUS_MODE, 11'd0, 10'd0, 21'h000000, M_ZERO, 1'b0},
        '{ROW_CFG, CFG_ENTRY_COUNT, 11'd3, 10'd0, 21'h000000, M_ZERO, 1'b0},
        '{ROW_LOOKUP, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'h055555, M_ZERO, 1'b0},
        '{ROW_LOOKUP, CFG_ENTRY_COUNT, 11'd0, 10'd1023, 21'h000000, M_ZERO, 1'b0},
        '{ROW_LOOKUP, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'h0AAAAB, M_ZERO, 1'b1},
        '{ROW_LOOKUP, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'h10FFFF, M_ZERO, 1'b1},
        '{ROW_CFG, CFG_ENTRY_COUNT, 11'd2047, 10'd0, 21'h000000, M_ZERO, 1'b0},
        '{ROW_CFG, CFG_CONTINUOUS_MODE, 11'd1, 10'd0, 21'h000000, M_ZERO, 1'b0},
        '{ROW_LOOKUP, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'd1023, M_ZERO, 1'b0},
        '{ROW_LOOKUP, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'd1024, M_ZERO, 1'b1},
        '{ROW_LOOKUP, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'd2, M_ZERO, 1'b0},
        '{ROW_LOAD, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'd100, M_MIX, 1'b1},
        '{ROW_LOOKUP, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'd99, M_ZERO, 1'b1},
        '{ROW_LOOKUP, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'd100, M_ZERO, 1'b0},
        '{ROW_LOOKUP, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'd1123, M_ZERO, 1'b0},
        '{ROW_CFG, CFG_ENTRY_COUNT, 11'd1, 10'd0, 21'h000000, M_ZERO, 1'b0},
        '{ROW_LOOKUP, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'd101, M_ZERO, 1'b1},
        '{ROW_LOOKUP, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'd100, M_ZERO, 1'b0},
        '{ROW_CFG, CFG_CONTINUOUS_MODE, 11'd0, 10'd0, 21'h000000, M_ZERO, 1'b0},
        '{ROW_CFG, CFG_ENTRY_COUNT, 11'd3, 10'd0, 21'h000000, M_ZERO, 1'b0},
        '{ROW_LOAD, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'd30, M_HIGH, 1'b1},
        '{ROW_LOAD, CFG_ENTRY_COUNT, 11'd0, 10'd1, 21'd10, M_ALTA, 1'b1},
        '{ROW_LOAD, CFG_ENTRY_COUNT, 11'd0, 10'd2, 21'd20, M_ALT5, 1'b1},
        '{ROW_LOOKUP, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'd10, M_ZERO, 1'b0},
        '{ROW_LOOKUP, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'd30, M_ZERO, 1'b1},
        '{ROW_LOOKUP, CFG_ENTRY_COUNT, 11'd0, 10'd0, 21'd20, M_ZERO, 1'b0}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [ACTION_W-1:0]       action;
    logic [ENTRY_INDEX_W-1:0]  entry_index;
    logic [CODE_POINT_W-1:0]   code_point;
    logic [DIM_W-1:0]          glyph_width;
    logic [DIM_W-1:0]          glyph_height;
    logic signed [OFFSET_W-1:0] offset_x;
    logic signed [OFFSET_W-1:0] offset_y;
    logic signed [OFFSET_W-1:0] advance;
    logic                      out_valid;
    logic                      out_stall;
    logic                      found;
    logic [GLYPH_INDEX_W-1:0]  glyph_index;
    logic [DIM_W-1:0]          out_width;
    logic [DIM_W-1:0]          out_height;
    logic signed [OFFSET_W-1:0] out_offset_x;
    logic signed [OFFSET_W-1:0] out_offset_y;
    logic signed [OFFSET_W-1:0] out_advance;

    logic [CODE_POINT_W-1:0]   code_mirror [TABLE_DEPTH];
    gtl_metric_t               metric_mirror [TABLE_DEPTH];
    bit                        written [TABLE_DEPTH];
    bit                        fresh [TABLE_DEPTH];
    logic                      mode_mirror;
    logic [ENTRY_COUNT_W-1:0]  count_mirror;
    bit                        tidy_phase;
    int                        plan_base;
    int                        plan_step;
    glyph_result_t             expected_glyphs [$];
    int                        items_accepted;
    int                        failures;
    int                        sender_burst;
    logic                      hold_request;

    glyph_table_lookup #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .entry_index  (entry_index),
        .code_point   (code_point),
        .glyph_width  (glyph_width),
        .glyph_height (glyph_height),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .glyph_index  (glyph_index),
        .out_width    (out_width),
        .out_height   (out_height),
        .out_offset_x (out_offset_x),
        .out_offset_y (out_offset_y),
        .out_advance  (out_advance)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic usable(input int slot);
        return tidy_phase ? fresh[slot] : written[slot];
    endfunction

    function automatic logic [CODE_POINT_W-1:0] plan_code(input int slot);
        return CODE_POINT_W'(plan_base + slot * plan_step);
    endfunction

    // Search the mirrored table; missing names the first slot the search would
    // touch before it holds a usable entry, or -1.
    function automatic glyph_result_t table_search(input logic [CODE_POINT_W-1:0] key,
                                                   output int missing);
        glyph_result_t hit_result;
        int            n;
        int            lo;
        int            hi;
        int            mid;
        int            hit;
        int            diff;
        hit_result = '0;
        missing = -1;
        hit = -1;
        n = (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_mirror);
        if (n != 0)
        begin
            if (mode_mirror)
            begin
                if (!usable(0))
                    missing = 0;
                else
                begin
                    diff = int'(key) - int'(code_mirror[0]);
                    if (diff >= 0 && diff < n)
                        hit = diff;
                end
            end
            else
            begin
                lo = 0;
                hi = n - 1;
                while (lo <= hi && hit < 0 && missing < 0)
                begin
                    mid = (lo + hi) / 2;
                    if (!usable(mid))
                        missing = mid;
                    else if (code_mirror[mid] < key)
                        lo = mid + 1;
                    else if (key < code_mirror[mid])
                        hi = mid - 1;
                    else
                        hit = mid;
                end
            end
        end
        if (hit >= 0 && missing < 0 && !usable(hit))
            missing = hit;
        if (hit >= 0)
        begin
            hit_result.found = 1'b1;
            hit_result.glyph_idx = hit[GLYPH_INDEX_W-1:0];
            hit_result.metric = metric_mirror[hit];
        end
        return hit_result;
    endfunction

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_glyphs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        if (index == CFG_CONTINUOUS_MODE)
            mode_mirror = value[0];
        else
            count_mirror = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_item(input glyph_item_t item, input logic zero_result);
        int            gap;
        int            r;
        int            missing;
        glyph_result_t want;
        gap = 0;
        r = $urandom_range(0, 99);
        if (sender_burst > 0)
            sender_burst--;
        else if (r < 4)
            sender_burst = $urandom_range(20, 60);
        else if (r < 60)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action       <= item.action;
        entry_index  <= item.slot;
        code_point   <= item.code;
        glyph_width  <= item.metric.width;
        glyph_height <= item.metric.height;
        offset_x     <= item.metric.offset_x;
        offset_y     <= item.metric.offset_y;
        advance      <= item.metric.advance;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = '0;
        if (item.action == ACTION_LOAD)
        begin
            code_mirror[item.slot]   = item.code;
            metric_mirror[item.slot] = item.metric;
            written[item.slot]       = 1'b1;
            fresh[item.slot]         = 1'b1;
        end
        else if (!zero_result)
            want = table_search(item.code, missing);
        expected_glyphs.push_back(want);
        items_accepted++;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        glyph_result_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (expected_glyphs.size() == 0)
            begin
                $display("%0t ns: unexpected transaction, actual found %b glyph_index %0d",
                         $time, found, glyph_index);
                failures++;
            end
            else
            begin
                want = expected_glyphs.pop_front();
                check_field("found", 16'(want.found), 16'(found));
                check_field("glyph_index", 16'(want.glyph_idx), 16'(glyph_index));
                check_field("out_width", want.metric.width, out_width);
                check_field("out_height", want.metric.height, out_height);
                check_field("out_offset_x", 16'(want.metric.offset_x), 16'(out_offset_x));
                check_field("out_offset_y", 16'(want.metric.offset_y), 16'(out_offset_y));
                check_field("out_advance", 16'(want.metric.advance), 16'(out_advance));
            end
        end
    end

    initial
    begin
        int stall_left;
        int quiet_left;
        int r;
        stall_left = 0;
        quiet_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            r = $urandom_range(0, 99);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (quiet_left > 0)
            begin
                out_stall <= 1'b0;
                quiet_left--;
            end
            else if (r < 4)
            begin
                out_stall <= 1'b0;
                quiet_left = 60;
            end
            else if (r < 65)
                out_stall <= 1'b0;
            else if (r < 93)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(10, 40);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("glyph_table_lookup regression: fail");
        $finish;
    end

    initial
    begin
        glyph_item_t   item;
        logic [63:0]   noise;
        logic          mode;
        int            row;
        int            phase;
        int            count;
        int            n;
        int            r;
        int            s;
        int            key;
        int            missing;
        int            random_start;
        foreach (code_mirror[i])
        begin
            code_mirror[i]   = '0;
            metric_mirror[i] = '0;
        end
        items_accepted = 0;
        failures       = 0;
        sender_burst   = 0;
        hold_request   = 1'b0;
        tidy_phase     = 1'b0;
        plan_base      = 0;
        plan_step      = 1;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_CONTINUOUS_MODE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        action         = ACTION_LOAD;
        entry_index    = '0;
        code_point     = '0;
        glyph_width    = '0;
        glyph_height   = '0;
        offset_x       = '0;
        offset_y       = '0;
        advance        = '0;
        mode_mirror    = 1'b0;
        count_mirror   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            if (directed_rows[row].kind == ROW_CFG)
                cfg_write(directed_rows[row].reg_index, directed_rows[row].reg_value);
            else
            begin
                item.action = (directed_rows[row].kind == ROW_LOAD) ? ACTION_LOAD
                                                                     : ACTION_LOOKUP;
                item.slot   = directed_rows[row].slot;
                item.code   = directed_rows[row].code;
                item.metric = directed_rows[row].metric;
                send_item(item, directed_rows[row].miss);
            end
        end

        random_start = items_accepted;
        phase = 0;
        while (items_accepted - random_start < RANDOM_ITEMS)
        begin
            case (phase)
                0:
                begin
                    mode = 1'b0;
                    count = TABLE_DEPTH;
                end
                1:
                begin
                    mode = 1'b1;
                    count = TABLE_DEPTH;
                end
                default:
                begin
                    mode = 1'($urandom_range(0, 1));
                    r = $urandom_range(0, 99);
                    if (r < 8)
                        count = 0;
                    else if (r < 16)
                        count = 1;
                    else if (r < 22)
                        count = TABLE_DEPTH;
                    else if (r < 28)
                        count = $urandom_range(TABLE_DEPTH + 1, 2047);
                    else if (r < 34)
                        count = $urandom_range(100, TABLE_DEPTH - 1);
                    else
                        count = $urandom_range(2, 40);
                end
            endcase
            cfg_write(CFG_CONTINUOUS_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
            cfg_write(CFG_ENTRY_COUNT, count[CFG_DATA_W-1:0]);
            tidy_phase = ($urandom_range(0, 99) < 80);
            foreach (fresh[i])
                fresh[i] = 1'b0;
            plan_step = mode ? 1 : $urandom_range(1, 3);
            plan_base = $urandom_range(0, CODE_MAX - (TABLE_DEPTH - 1) * plan_step);
            n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
            // hold the result side while the sender keeps offering
            if (phase == 3)
                hold_request = 1'b1;
            repeat ($urandom_range(20, 60))
            begin
                noise = {$urandom(), $urandom()};
                item.metric = noise[55:0];
                item.slot = ENTRY_INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
                if ($urandom_range(0, 99) < 25)
                begin
                    item.action = ACTION_LOAD;
                    if (n != 0 && $urandom_range(0, 99) < 70)
                        item.slot = ENTRY_INDEX_W'($urandom_range(0, n - 1));
                    item.code = tidy_phase ? plan_code(item.slot)
                                           : CODE_POINT_W'($urandom_range(0, CODE_MAX));
                end
                else
                begin
                    item.action = ACTION_LOOKUP;
                    s = (n == 0) ? 0 : $urandom_range(0, n - 1);
                    r = $urandom_range(0, 99);
                    if (r < 15 || n == 0)
                        key = $urandom_range(0, CODE_MAX);
                    else if (tidy_phase)
                    begin
                        key = plan_code(s);
                        if (r < 25)
                            key = key + 1;
                        else if (r < 35 && key > 0)
                            key = key - 1;
                    end
                    else
                        key = (r < 65) ? int'(code_mirror[s]) : int'(code_mirror[s]) + 1;
                    if (key > CODE_MAX)
                        key = CODE_MAX;
                    item.code = key[CODE_POINT_W-1:0];
                    void'(table_search(item.code, missing));
                    // fill the slot the search would trip on
                    if (missing >= 0)
                    begin
                        item.action = ACTION_LOAD;
                        item.slot = missing[ENTRY_INDEX_W-1:0];
                        item.code = tidy_phase ? plan_code(missing)
                                               : CODE_POINT_W'($urandom_range(0, CODE_MAX));
                    end
                end
                send_item(item, 1'b0);
            end
            phase++;
        end

        wait_idle();
        if (failures == 0)
            $display("glyph_table_lookup regression: pass");
        else
            $display("glyph_table_lookup regression: fail");
        $finish;
    end

endmodule

### files.f
hdl/gtl_pkg.sv
hdl/gtl_ctrl.sv
hdl/gtl_datapath.sv
hdl/glyph_table_lookup.sv
bench/glyph_table_lookup_tb.sv
